>>> rtl/bpd_pkg.sv
// bpd_pkg: shared types, constants and the keyword table of the detokenizer
// no dependencies
package bpd_pkg;

    localparam int MaxChars = 8;
    localparam int QDepth   = 2;

    localparam logic [7:0] ChNewline = 8'h0A;
    localparam logic [7:0] ChSpace   = 8'h20;
    localparam logic [7:0] ChZero    = 8'h30;

    // kind of work handed from front to back
    typedef enum logic [2:0] {
        JOB_NONE,
        JOB_NUMBER,
        JOB_CHAR,
        JOB_KEYWORD,
        JOB_NEWLINE
    } job_kind_t;

    // one queued job
    typedef struct packed {
        job_kind_t   kind;
        logic [15:0] line_num;
        logic [7:0]  data;
        logic        add_newline;
    } job_t;

    // keyword text, packed first char in the top byte, with its length
    typedef struct packed {
        logic [55:0] text;
        logic [2:0]  len;
    } keyword_t;

    function automatic keyword_t kw(input logic [6:0] idx);
        keyword_t k;
        k.text = '0;
        k.len  = 3'd0;
        case (idx)
            7'd0:   begin k.text = {"LONG", 24'h0};     k.len = 3'd4; end
            7'd1:   begin k.text = {"FOR", 32'h0};      k.len = 3'd3; end
            7'd2:   begin k.text = {"COLOR", 16'h0};    k.len = 3'd5; end
            7'd3:   begin k.text = {"PLOT", 24'h0};     k.len = 3'd4; end
            7'd4:   begin k.text = {"CLS", 32'h0};      k.len = 3'd3; end
            7'd5:   begin k.text = {"XELSE", 16'h0};    k.len = 3'd5; end
            7'd6:   begin k.text = {"RANDOM", 8'h0};    k.len = 3'd6; end
            7'd7:   begin k.text = {"NEXT", 24'h0};     k.len = 3'd4; end
            7'd8:   begin k.text = {"DATA", 24'h0};     k.len = 3'd4; end
            7'd9:   begin k.text = {"INPUT", 16'h0};    k.len = 3'd5; end
            7'd10:  begin k.text = {"DIM", 32'h0};      k.len = 3'd3; end
            7'd11:  begin k.text = {"READ", 24'h0};     k.len = 3'd4; end
            7'd12:  begin k.text = {"LET", 32'h0};      k.len = 3'd3; end
            7'd13:  begin k.text = {"GOTO", 24'h0};     k.len = 3'd4; end
            7'd14:  begin k.text = {"RUN", 32'h0};      k.len = 3'd3; end
            7'd15:  begin k.text = {"IF", 40'h0};       k.len = 3'd2; end
            7'd16:  begin k.text = {"RESTORE"};         k.len = 3'd7; end
            7'd17:  begin k.text = {"GOSUB", 16'h0};    k.len = 3'd5; end
            7'd18:  begin k.text = {"RETURN", 8'h0};    k.len = 3'd6; end
            7'd19:  begin k.text = {"REM", 32'h0};      k.len = 3'd3; end
            7'd20:  begin k.text = {"STOP", 24'h0};     k.len = 3'd4; end
            7'd21:  begin k.text = {"ELSE", 24'h0};     k.len = 3'd4; end
            7'd22:  begin k.text = {"TRON", 24'h0};     k.len = 3'd4; end
            7'd23:  begin k.text = {"TROFF", 16'h0};    k.len = 3'd5; end
            7'd24:  begin k.text = {"DEFSTR", 8'h0};    k.len = 3'd6; end
            7'd25:  begin k.text = {"DEFINT", 8'h0};    k.len = 3'd6; end
            7'd26:  begin k.text = {"DEFSNG", 8'h0};    k.len = 3'd6; end
            7'd27:  begin k.text = {"DEFDBL", 8'h0};    k.len = 3'd6; end
            7'd28:  begin k.text = {"FILL", 24'h0};     k.len = 3'd4; end
            7'd29:  begin k.text = {"SWAP", 24'h0};     k.len = 3'd4; end
            7'd30:  begin k.text = {"SOUND", 16'h0};    k.len = 3'd5; end
            7'd31:  begin k.text = {"END", 32'h0};      k.len = 3'd3; end
            7'd32:  begin k.text = {"OUTSLOT"};         k.len = 3'd7; end
            7'd33:  begin k.text = {"ON", 40'h0};       k.len = 3'd2; end
            7'd34:  begin k.text = {"OPEN", 24'h0};     k.len = 3'd4; end
            7'd35:  begin k.text = {"ROUTE", 16'h0};    k.len = 3'd5; end
            7'd36:  begin k.text = {"RATIO", 16'h0};    k.len = 3'd5; end
            7'd37:  begin k.text = {"CIRCLE", 8'h0};    k.len = 3'd6; end
            7'd38:  begin k.text = {"CLOSE", 16'h0};    k.len = 3'd5; end
            7'd39:  begin k.text = {"MACHLG", 8'h0};    k.len = 3'd6; end
            7'd40:  begin k.text = {"LOCATE", 8'h0};    k.len = 3'd6; end
            7'd41:  begin k.text = {"WIDTH", 16'h0};    k.len = 3'd5; end
            7'd42:  begin k.text = {"KILL", 24'h0};     k.len = 3'd4; end
            7'd43:  begin k.text = {"BOX", 32'h0};      k.len = 3'd3; end
            7'd44:  begin k.text = {"RECORD", 8'h0};    k.len = 3'd6; end
            7'd45:  begin k.text = {"CALL", 24'h0};     k.len = 3'd4; end
            7'd46:  begin k.text = {"MODE", 24'h0};     k.len = 3'd4; end
            7'd47:  begin k.text = {"LPRINT", 8'h0};    k.len = 3'd6; end
            7'd48:  begin k.text = {"DEF", 32'h0};      k.len = 3'd3; end
            7'd49:  begin k.text = {"POKE", 24'h0};     k.len = 3'd4; end
            7'd50:  begin k.text = {"PRINT", 16'h0};    k.len = 3'd5; end
            7'd51:  begin k.text = {"WRITE", 16'h0};    k.len = 3'd5; end
            7'd52:  begin k.text = {"DO", 40'h0};       k.len = 3'd2; end
            7'd53:  begin k.text = {"UNTIL", 16'h0};    k.len = 3'd5; end
            7'd54:  begin k.text = {"DELAY", 16'h0};    k.len = 3'd5; end
            7'd55:  begin k.text = {"RENAME", 8'h0};    k.len = 3'd6; end
            7'd56:  begin k.text = {"CLEAR", 16'h0};    k.len = 3'd5; end
            7'd57:  begin k.text = {"WHILE", 16'h0};    k.len = 3'd5; end
            7'd58:  begin k.text = {"WEND", 24'h0};     k.len = 3'd4; end
            7'd59:  begin k.text = {"PAGE", 24'h0};     k.len = 3'd4; end
            7'd60:  begin k.text = {"INDEXF", 8'h0};    k.len = 3'd6; end
            7'd61:  begin k.text = {"LINE", 24'h0};     k.len = 3'd4; end
            7'd62:  begin k.text = {"FN", 40'h0};       k.len = 3'd2; end
            7'd63:  begin k.text = {"USR", 32'h0};      k.len = 3'd3; end
            7'd64:  begin k.text = {"ERROR", 16'h0};    k.len = 3'd5; end
            7'd65:  begin k.text = {"VARPTR", 8'h0};    k.len = 3'd6; end
            7'd66:  begin k.text = {"INSTR", 16'h0};    k.len = 3'd5; end
            7'd67:  begin k.text = {"POINT", 16'h0};    k.len = 3'd5; end
            7'd68:  begin k.text = {"MEM", 32'h0};      k.len = 3'd3; end
            7'd69:  begin k.text = {"NOT", 32'h0};      k.len = 3'd3; end
            7'd70:  begin k.text = {"MAYBE", 16'h0};    k.len = 3'd5; end
            7'd71:  begin k.text = {"PEEK", 24'h0};     k.len = 3'd4; end
            7'd72:  begin k.text = {"SPC", 32'h0};      k.len = 3'd3; end
            7'd73:  begin k.text = {"USING", 16'h0};    k.len = 3'd5; end
            7'd74:  begin k.text = {"TAB", 32'h0};      k.len = 3'd3; end
            7'd75:  begin k.text = {"WORD", 24'h0};     k.len = 3'd4; end
            7'd76:  begin k.text = {"TO", 40'h0};       k.len = 3'd2; end
            7'd77:  begin k.text = {"THEN", 24'h0};     k.len = 3'd4; end
            7'd78:  begin k.text = {"STEP", 24'h0};     k.len = 3'd4; end
            7'd79:  begin k.text = {"AND", 32'h0};      k.len = 3'd3; end
            7'd80:  begin k.text = {"OR", 40'h0};       k.len = 3'd2; end
            7'd81:  begin k.text = {"XOR", 32'h0};      k.len = 3'd3; end
            7'd82:  begin k.text = {"MOD", 32'h0};      k.len = 3'd3; end
            7'd83:  begin k.text = {"FRAC", 24'h0};     k.len = 3'd4; end
            7'd84:  begin k.text = {"FIX", 32'h0};      k.len = 3'd3; end
            7'd85:  begin k.text = {"LEN", 32'h0};      k.len = 3'd3; end
            7'd86:  begin k.text = {"VAL", 32'h0};      k.len = 3'd3; end
            7'd87:  begin k.text = {"ASC", 32'h0};      k.len = 3'd3; end
            7'd88:  begin k.text = {"SGN", 32'h0};      k.len = 3'd3; end
            7'd89:  begin k.text = {"INT", 32'h0};      k.len = 3'd3; end
            7'd90:  begin k.text = {"ABS", 32'h0};      k.len = 3'd3; end
            7'd91:  begin k.text = {"INSLOT", 8'h0};    k.len = 3'd6; end
            7'd92:  begin k.text = {"POS", 32'h0};      k.len = 3'd3; end
            7'd93:  begin k.text = {"SQR", 32'h0};      k.len = 3'd3; end
            7'd94:  begin k.text = {"RND", 32'h0};      k.len = 3'd3; end
            7'd95:  begin k.text = {"LOG", 32'h0};      k.len = 3'd3; end
            7'd96:  begin k.text = {"EXP", 32'h0};      k.len = 3'd3; end
            7'd97:  begin k.text = {"COS", 32'h0};      k.len = 3'd3; end
            7'd98:  begin k.text = {"SIN", 32'h0};      k.len = 3'd3; end
            7'd99:  begin k.text = {"TAN", 32'h0};      k.len = 3'd3; end
            7'd100: begin k.text = {"ATN", 32'h0};      k.len = 3'd3; end
            7'd101: begin k.text = {"CVI", 32'h0};      k.len = 3'd3; end
            7'd102: begin k.text = {"CVB", 32'h0};      k.len = 3'd3; end
            7'd103: begin k.text = {"MOUSE", 16'h0};    k.len = 3'd5; end
            7'd104: begin k.text = {"REC", 32'h0};      k.len = 3'd3; end
            7'd105: begin k.text = {"LOC", 32'h0};      k.len = 3'd3; end
            7'd106: begin k.text = {"LOF", 32'h0};      k.len = 3'd3; end
            7'd107: begin k.text = {"PSTR$", 16'h0};    k.len = 3'd5; end
            7'd108: begin k.text = {"MKI$", 24'h0};     k.len = 3'd4; end
            7'd109: begin k.text = {"MKB$", 24'h0};     k.len = 3'd4; end
            7'd110: begin k.text = {"CHR$", 24'h0};     k.len = 3'd4; end
            7'd111: begin k.text = {"HEX$", 24'h0};     k.len = 3'd4; end
            7'd112: begin k.text = {"OCT$", 24'h0};     k.len = 3'd4; end
            7'd113: begin k.text = {"BIN$", 24'h0};     k.len = 3'd4; end
            7'd114: begin k.text = {"UNS$", 24'h0};     k.len = 3'd4; end
            7'd115: begin k.text = {"STR$", 24'h0};     k.len = 3'd4; end
            7'd116: begin k.text = {"INDEX$", 8'h0};    k.len = 3'd6; end
            7'd117: begin k.text = {"ERRMSG$"};         k.len = 3'd7; end
            7'd118: begin k.text = {"TIME$", 16'h0};    k.len = 3'd5; end
            7'd119: begin k.text = {"DATE$", 16'h0};    k.len = 3'd5; end
            7'd120: begin k.text = {"INKEY$", 8'h0};    k.len = 3'd6; end
            7'd121: begin k.text = {"LEFT$", 16'h0};    k.len = 3'd5; end
            7'd122: begin k.text = {"RIGHT$", 8'h0};    k.len = 3'd6; end
            7'd123: begin k.text = {"MID$", 24'h0};     k.len = 3'd4; end
            7'd124: begin k.text = {"STRING$"};         k.len = 3'd7; end
            7'd125: begin k.text = {"SPACE$", 8'h0};    k.len = 3'd6; end
            7'd126: begin k.text = {"UCASE$", 8'h0};    k.len = 3'd6; end
            default: begin k.text = {"* END *"};        k.len = 3'd7; end
        endcase
        return k;
    endfunction

endpackage

>>> rtl/bpd_front.sv
// bpd_front: accepts raw bytes, tracks record phase, emits jobs
// depends on bpd_pkg
module bpd_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic [7:0]    in_byte,
    input  logic          end_of_input,
    input  logic          in_valid,
    output logic          in_stall,
    output bpd_pkg::job_t job,
    output logic          job_valid,
    input  logic          job_stall
);

    typedef enum logic [1:0] {
        PH_LOW,
        PH_HIGH,
        PH_LEN,
        PH_BODY
    } phase_t;

    phase_t         phase_reg, phase_next;
    logic [7:0]     line_low_reg, line_low_next;
    logic [7:0]     left_reg, left_next;
    logic           done_reg, done_next;
    bpd_pkg::job_t  job_next;

    logic           take;

    // a new byte is taken whenever the queue can hold its job
    assign in_stall = job_stall;
    assign take     = in_valid && !job_stall;

    // classify the byte into a job and advance the record phase
    always_comb
    begin
        phase_next    = phase_reg;
        line_low_next = line_low_reg;
        left_next     = left_reg;
        done_next     = done_reg;
        job_next.kind        = bpd_pkg::JOB_NONE;
        job_next.line_num    = {in_byte, line_low_reg};
        job_next.data        = in_byte;
        job_next.add_newline = 1'b0;
        if (!done_reg)
        begin
            if (end_of_input)
            begin
                done_next  = 1'b1;
                phase_next = PH_LOW;
                left_next  = 8'd0;
                if (phase_reg == PH_BODY)
                    job_next.kind = bpd_pkg::JOB_NEWLINE;
            end
            else
            begin
                case (phase_reg)
                    PH_LOW:
                    begin
                        line_low_next = in_byte;
                        phase_next    = PH_HIGH;
                    end
                    PH_HIGH:
                    begin
                        job_next.kind = bpd_pkg::JOB_NUMBER;
                        phase_next    = PH_LEN;
                    end
                    PH_LEN:
                    begin
                        if (in_byte <= 8'd1)
                        begin
                            job_next.kind = bpd_pkg::JOB_NEWLINE;
                            phase_next    = PH_LOW;
                            left_next     = 8'd0;
                        end
                        else
                        begin
                            left_next  = in_byte - 8'd1;
                            phase_next = PH_BODY;
                        end
                    end
                    default:
                    begin
                        job_next.kind = in_byte[7] ? bpd_pkg::JOB_KEYWORD
                                                   : bpd_pkg::JOB_CHAR;
                        if (left_reg > 8'd0)
                            left_next = left_reg - 8'd1;
                        if (left_next == 8'd0)
                        begin
                            job_next.add_newline = 1'b1;
                            phase_next           = PH_LOW;
                        end
                    end
                endcase
            end
        end
    end

    assign job       = job_next;
    assign job_valid = in_valid && (job_next.kind != bpd_pkg::JOB_NONE);

    // record state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_LOW;
            left_reg  <= 8'd0;
            done_reg  <= 1'b0;
        end
        else if (take)
        begin
            phase_reg <= phase_next;
            left_reg  <= left_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            line_low_reg <= line_low_next;
    end

endmodule

>>> rtl/bpd_queue.sv
// bpd_queue: small job queue between front and back
// depends on bpd_pkg
module bpd_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  bpd_pkg::job_t wr_job,
    input  logic          wr_valid,
    output logic          wr_stall,
    output bpd_pkg::job_t rd_job,
    output logic          rd_valid,
    input  logic          rd_take
);

    localparam int PtrW = $clog2(bpd_pkg::QDepth);

    bpd_pkg::job_t         slot_reg [bpd_pkg::QDepth];
    logic [PtrW-1:0]       wptr_reg, rptr_reg;
    logic [PtrW:0]         count_reg;
    logic                  push, pop;

    assign wr_stall = (count_reg == (PtrW+1)'(bpd_pkg::QDepth));
    assign rd_valid = (count_reg != '0);
    assign rd_job   = slot_reg[rptr_reg];
    assign push     = wr_valid && !wr_stall;
    assign pop      = rd_take && rd_valid;

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
                wptr_reg <= wptr_reg + PtrW'(1);
            if (pop)
                rptr_reg <= rptr_reg + PtrW'(1);
            count_reg <= count_reg + (PtrW+1)'(push) - (PtrW+1)'(pop);
        end
    end

    // job storage
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wptr_reg] <= wr_job;
    end

endmodule

>>> rtl/bpd_back.sv
// bpd_back: expands jobs into characters, one per cycle while the output is not stalled, into an output register
// depends on bpd_pkg
module bpd_back (
    input  logic          clk,
    input  logic          rst_n,
    input  bpd_pkg::job_t job,
    input  logic          job_valid,
    output logic          job_take,
    output logic [7:0]    out_char,
    output logic          last_of_run,
    output logic          out_valid,
    input  logic          out_stall
);

    logic [7:0]  idx_reg, idx_next;
    logic [3:0]  count;
    logic [7:0]  ch;
    logic [16:0] rem_reg, rem_cur, rem_next;
    logic [16:0] place;
    logic [16:0] thr;
    logic [3:0]  digit;
    logic [2:0]  pos;
    logic [7:0]  char_reg;
    logic        last_reg, valid_reg;
    logic        adv;
    bpd_pkg::keyword_t kwd;

    // line-number digits: compare against multiples of the decimal place,
    // the remainder is kept for the next digit
    always_comb
    begin
        rem_cur = (pos == 3'd0) ? {1'b0, job.line_num} : rem_reg;
        case (pos)
            3'd0:    place = 17'd10000;
            3'd1:    place = 17'd1000;
            3'd2:    place = 17'd100;
            3'd3:    place = 17'd10;
            default: place = 17'd1;
        endcase
        digit = 4'd0;
        thr   = '0;
        for (int k = 1; k < 10; k++)
        begin
            case (pos)
                3'd0:    thr = 17'(k * 10000);
                3'd1:    thr = 17'(k * 1000);
                3'd2:    thr = 17'(k * 100);
                3'd3:    thr = 17'(k * 10);
                default: thr = 17'(k);
            endcase
            if (rem_cur >= thr)
                digit = 4'(k);
        end
        rem_next = rem_cur - 17'(digit) * place;
    end

    assign kwd = bpd_pkg::kw(job.data[6:0]);
    assign pos = idx_reg[2:0];

    // character count and the character at the current index
    always_comb
    begin
        count = 4'd1;
        ch    = bpd_pkg::ChNewline;
        case (job.kind)
            bpd_pkg::JOB_NUMBER:
            begin
                count = 4'd6;
                ch    = (pos == 3'd5) ? bpd_pkg::ChSpace : (bpd_pkg::ChZero + 8'(digit));
            end
            bpd_pkg::JOB_CHAR:
            begin
                count = 4'd1 + 4'(job.add_newline);
                ch    = (pos == 3'd0) ? job.data : bpd_pkg::ChNewline;
            end
            bpd_pkg::JOB_KEYWORD:
            begin
                count = 4'(kwd.len) + 4'(job.add_newline);
                ch    = (pos < kwd.len) ? kwd.text[55 - 8*pos -: 8] : bpd_pkg::ChNewline;
            end
            default:
            begin
                count = 4'd1;
                ch    = bpd_pkg::ChNewline;
            end
        endcase
    end

    assign adv      = job_valid && (!valid_reg || !out_stall);
    assign job_take = adv && (idx_reg == 8'(count - 4'd1));
    assign idx_next = job_take ? 8'd0 : idx_reg + 8'd1;

    // character index, digit remainder and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 8'd0;
            rem_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                idx_reg <= idx_next;
                rem_reg <= rem_next;
            end
            if (adv)
                valid_reg <= 1'b1;
            else if (!out_stall)
                valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            char_reg <= ch;
            last_reg <= job_take;
        end
    end

    assign out_char    = char_reg;
    assign last_of_run = last_reg;
    assign out_valid   = valid_reg;

endmodule

>>> rtl/basic_program_detokenizer.sv
// basic_program_detokenizer: top level, front classifier, job queue, back expander
// depends on bpd_pkg, bpd_front, bpd_queue, bpd_back
//
//  channel | signals                          | direction
//  input   | in_byte end_of_input in_valid    | in, in_stall out
//  output  | out_char last_of_run out_valid   | out, out_stall in
//
// one input byte per cycle while the queue has room; the back sends one
// character per cycle while out_stall is low, and a byte yields 0 to 8 characters, set by the expander
// an accepted byte's job is registered in the queue, and its first character is then registered in the output register
// reset clears phase, queue and output valid; no clearing pass
// an output stall holds the character and backs up through the queue
module basic_program_detokenizer (
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] in_byte,
    input  logic       end_of_input,
    input  logic       in_valid,
    output logic       in_stall,
    output logic [7:0] out_char,
    output logic       last_of_run,
    output logic       out_valid,
    input  logic       out_stall
);

    bpd_pkg::job_t f_job, q_job;
    logic          f_valid, q_stall, q_valid, q_take;

    bpd_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_byte      (in_byte),
        .end_of_input (end_of_input),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .job          (f_job),
        .job_valid    (f_valid),
        .job_stall    (q_stall)
    );

    bpd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_job   (f_job),
        .wr_valid (f_valid),
        .wr_stall (q_stall),
        .rd_job   (q_job),
        .rd_valid (q_valid),
        .rd_take  (q_take)
    );

    bpd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .job         (q_job),
        .job_valid   (q_valid),
        .job_take    (q_take),
        .out_char    (out_char),
        .last_of_run (last_of_run),
        .out_valid   (out_valid),
        .out_stall   (out_stall)
    );

endmodule

>>> rtl/bpd_checker.sv
// bpd_checker: port-level checks for the detokenizer
// depends on basic_program_detokenizer ports only
module bpd_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic [7:0] out_char,
    input logic       last_of_run,
    input logic       out_valid,
    input logic       out_stall
);

    // a stalled output beat keeps its character
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_char)
            && $stable(last_of_run))
        else $error("output beat changed under stall");

    // nothing comes out right after reset
    a_rst: assert property (@(posedge clk) $rose(rst_n) |-> !out_valid)
        else $error("output valid at reset release");

    // a stalled input beat stays offered
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid)
        else $error("input beat dropped under stall");

    // input is not blocked when nothing is pending on the output
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid && $past(!out_valid) && $past(!out_valid, 2)
            && $past(!out_valid, 3) |-> !in_stall)
        else $error("input stalled with idle output");

endmodule

bind basic_program_detokenizer bpd_checker u_bpd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_char    (out_char),
    .last_of_run (last_of_run),
    .out_valid   (out_valid),
    .out_stall   (out_stall)
);

>>> verif/tb_basic_program_detokenizer.sv
// tb_basic_program_detokenizer: self-checking testbench for the detokenizer
// depends on bpd_pkg (newline, space and zero characters) and basic_program_detokenizer
module tb_basic_program_detokenizer;

    localparam int WatchLimit = 4000;
    localparam int MaxMsgs    = 10;

    // listing phases of the predictor
    typedef enum logic [1:0] {
        P_LOW,
        P_HIGH,
        P_LEN,
        P_BODY
    } lphase_t;

    typedef struct packed {
        logic [7:0] data;
        logic       eof;
    } in_beat_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } char_beat_t;

    logic       clk;
    logic       rst_n;
    logic [7:0] in_byte;
    logic       end_of_input;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] out_char;
    logic       last_of_run;
    logic       out_valid;
    logic       out_stall;

    in_beat_t   pending_bytes[$];
    char_beat_t listing_chars[$];

    lphase_t    lp;
    logic [7:0] lo_byte;
    logic [7:0] body_left;
    logic       eof_seen;

    int  mismatches;
    int  watch;
    int  in_gap;
    int  out_gap;
    bit  stim_done;

    basic_program_detokenizer DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_byte(in_byte),
        .end_of_input(end_of_input),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .out_char(out_char),
        .last_of_run(last_of_run),
        .out_valid(out_valid),
        .out_stall(out_stall)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // keyword spelling of a token byte
    function automatic string keyword_text(input logic [6:0] idx);
        string names[128];
        names = '{
            "LONG", "FOR", "COLOR", "PLOT", "CLS", "XELSE", "RANDOM", "NEXT",
            "DATA", "INPUT", "DIM", "READ", "LET", "GOTO", "RUN", "IF",
            "RESTORE", "GOSUB", "RETURN", "REM", "STOP", "ELSE", "TRON", "TROFF",
            "DEFSTR", "DEFINT", "DEFSNG", "DEFDBL", "FILL", "SWAP", "SOUND", "END",
            "OUTSLOT", "ON", "OPEN", "ROUTE", "RATIO", "CIRCLE", "CLOSE", "MACHLG",
            "LOCATE", "WIDTH", "KILL", "BOX", "RECORD", "CALL", "MODE", "LPRINT",
            "DEF", "POKE", "PRINT", "WRITE", "DO", "UNTIL", "DELAY", "RENAME",
            "CLEAR", "WHILE", "WEND", "PAGE", "INDEXF", "LINE", "FN", "USR",
            "ERROR", "VARPTR", "INSTR", "POINT", "MEM", "NOT", "MAYBE", "PEEK",
            "SPC", "USING", "TAB", "WORD", "TO", "THEN", "STEP", "AND",
            "OR", "XOR", "MOD", "FRAC", "FIX", "LEN", "VAL", "ASC",
            "SGN", "INT", "ABS", "INSLOT", "POS", "SQR", "RND", "LOG",
            "EXP", "COS", "SIN", "TAN", "ATN", "CVI", "CVB", "MOUSE",
            "REC", "LOC", "LOF", "PSTR$", "MKI$", "MKB$", "CHR$", "HEX$",
            "OCT$", "BIN$", "UNS$", "STR$", "INDEX$", "ERRMSG$", "TIME$", "DATE$",
            "INKEY$", "LEFT$", "RIGHT$", "MID$", "STRING$", "SPACE$", "UCASE$",
            "* END *"
        };
        return names[idx];
    endfunction

    // expand one accepted byte into listing characters
    task automatic expand_byte(input in_beat_t b);
        logic [7:0] run[$];
        int         num;
        int         dv;
        string      s;
        if (eof_seen)
            return;
        if (b.eof)
        begin
            eof_seen = 1'b1;
            if (lp == P_BODY)
                run.push_back(bpd_pkg::ChNewline);
            lp = P_LOW;
            body_left = '0;
        end
        else
        begin
            case (lp)
                P_LOW:
                begin
                    lo_byte = b.data;
                    lp = P_HIGH;
                end
                P_HIGH:
                begin
                    num = {b.data, lo_byte};
                    dv = 10000;
                    while (dv > 0)
                    begin
                        run.push_back(bpd_pkg::ChZero + 8'((num / dv) % 10));
                        dv = dv / 10;
                    end
                    run.push_back(bpd_pkg::ChSpace);
                    lp = P_LEN;
                end
                P_LEN:
                begin
                    if (b.data <= 8'd1)
                    begin
                        run.push_back(bpd_pkg::ChNewline);
                        lp = P_LOW;
                        body_left = '0;
                    end
                    else
                    begin
                        body_left = b.data - 8'd1;
                        lp = P_BODY;
                    end
                end
                default:
                begin
                    if (b.data[7])
                    begin
                        s = keyword_text(b.data[6:0]);
                        for (int i = 0; i < s.len(); i++)
                            run.push_back(s[i]);
                    end
                    else
                        run.push_back(b.data);
                    if (body_left > 0)
                        body_left = body_left - 8'd1;
                    if (body_left == 0)
                    begin
                        run.push_back(bpd_pkg::ChNewline);
                        lp = P_LOW;
                    end
                end
            endcase
        end
        foreach (run[i])
            listing_chars.push_back('{ch: run[i], last: (i == run.size() - 1)});
    endtask

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic push_byte(input logic [7:0] d);
        pending_bytes.push_back('{data: d, eof: 1'b0});
    endtask

    // one record with a random body of the given length
    task automatic push_record(input logic [15:0] num, input int body_len, input int tok_pct);
        push_byte(num[7:0]);
        push_byte(num[15:8]);
        push_byte(8'(body_len + 1));
        for (int i = 0; i < body_len; i++)
        begin
            if ($urandom_range(0, 99) < tok_pct)
                push_byte(8'($urandom_range(128, 255)));
            else
                push_byte(8'($urandom_range(0, 127)));
        end
    endtask

    // stimulus
    initial
    begin
        int n;
        // directed: line number extremes, empty records, every token edge
        push_record(16'd0, 0, 0);
        pending_bytes[2].data = 8'd0;
        push_record(16'hFFFF, 0, 0);
        push_record(16'd12345, 4, 0);
        pending_bytes[pending_bytes.size() - 4].data = 8'd0;
        pending_bytes[pending_bytes.size() - 3].data = 8'd127;
        pending_bytes[pending_bytes.size() - 2].data = 8'd128;
        pending_bytes[pending_bytes.size() - 1].data = 8'd255;
        push_record(16'd40000, 2, 0);
        pending_bytes[pending_bytes.size() - 2].data = 8'd245;
        pending_bytes[pending_bytes.size() - 1].data = 8'd254;
        // random: well-formed records, some long bodies
        n = 0;
        while (n < 100)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                push_record(16'($urandom), $urandom_range(0, 255) > 200 ?
                            $urandom_range(20, 40) : $urandom_range(0, 6), 40);
            end
            else
                push_record(16'($urandom), $urandom_range(0, 6), 50);
            n = pending_bytes.size() - 15;
        end
        // end of input inside a body, then ignored bytes
        push_record(16'd777, 5, 50);
        void'(pending_bytes.pop_back());
        pending_bytes.push_back('{data: 8'($urandom), eof: 1'b1});
        pending_bytes.push_back('{data: 8'hFF, eof: 1'b1});
        push_byte(8'h81);
        stim_done = 1'b1;
    end

    // reset
    initial
    begin
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
    end

    // input driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_byte <= '0;
            end_of_input <= 1'b0;
            in_gap = 0;
            lp = P_LOW;
            lo_byte = '0;
            body_left = '0;
            eof_seen = 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                expand_byte('{data: in_byte, eof: end_of_input});
                in_gap = gap_len();
            end
            if (!in_valid || !in_stall)
            begin
                if (in_gap > 0 || pending_bytes.size() == 0)
                begin
                    if (in_gap > 0)
                        in_gap--;
                    in_valid <= 1'b0;
                end
                else
                begin
                    in_beat_t b;
                    b = pending_bytes.pop_front();
                    in_valid <= 1'b1;
                    in_byte <= b.data;
                    end_of_input <= b.eof;
                end
            end
        end
    end

    // output monitor and stall generator
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            out_gap = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (listing_chars.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MaxMsgs)
                        $display("unexpected char %h last %b", out_char, last_of_run);
                end
                else
                begin
                    char_beat_t e;
                    e = listing_chars.pop_front();
                    if (e.ch !== out_char || e.last !== last_of_run)
                    begin
                        mismatches++;
                        if (mismatches <= MaxMsgs)
                            $display("char mismatch: expected %h/%b got %h/%b",
                                     e.ch, e.last, out_char, last_of_run);
                    end
                end
                out_gap = gap_len();
            end
            if (out_gap > 0)
            begin
                out_gap--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // watchdog and end of run
    initial
    begin
        mismatches = 0;
        watch = 0;
        @(posedge rst_n);
        while (!(stim_done && pending_bytes.size() == 0 && !in_valid
                 && listing_chars.size() == 0))
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                watch = 0;
            else
                watch++;
            if (watch >= WatchLimit)
            begin
                $display("basic_program_detokenizer verification failed");
                $finish;
            end
        end
        repeat (40) @(posedge clk);
        if (mismatches == 0 && listing_chars.size() == 0)
            $display("basic_program_detokenizer verification clean");
        else
            $display("basic_program_detokenizer verification failed");
        $finish;
    end

endmodule

>>> filelist.f
rtl/bpd_pkg.sv
rtl/bpd_front.sv
rtl/bpd_queue.sv
rtl/bpd_back.sv
rtl/basic_program_detokenizer.sv
rtl/bpd_checker.sv
verif/tb_basic_program_detokenizer.sv
